// File: rtl/cpse_pkg.sv
// Package for the composite pixel sample encoder.
// Holds the lane count, the sine and DAC code tables and the shared types.
// Depends on nothing; every other file in rtl uses it by scoped names.
package cpse_pkg;

   localparam int LaneCount = 4;
   localparam int PhaseSteps = 12;
   localparam int BlankIndex = 5;

   // Phase offset, in steps of the twelve-step cycle, that each lane adds.
   localparam logic [3:0] LANE_OFFSET_0 = 4'd0;
   localparam logic [3:0] LANE_OFFSET_1 = 4'd3;
   localparam logic [3:0] LANE_OFFSET_2 = 4'd6;
   localparam logic [3:0] LANE_OFFSET_3 = 4'd9;

   typedef logic [3:0] sample_type;
   typedef sample_type [LaneCount-1:0] sample_vec_type;

   // Sine value, in amplitude steps, at a phase of 0 to 11.
   function automatic logic signed [2:0] sine_step(input logic [3:0] phase);
      logic signed [2:0] step;
      begin
         case (phase)
            4'd0:    step = 3'sd0;
            4'd1:    step = 3'sd1;
            4'd2:    step = 3'sd2;
            4'd3:    step = 3'sd2;
            4'd4:    step = 3'sd2;
            4'd5:    step = 3'sd1;
            4'd6:    step = 3'sd0;
            4'd7:    step = -3'sd1;
            4'd8:    step = -3'sd2;
            4'd9:    step = -3'sd2;
            4'd10:   step = -3'sd2;
            4'd11:   step = -3'sd1;
            default: step = 3'sd0;
         endcase
         return step;
      end
   endfunction

   // Amplitude index to 4-bit DAC code.
   function automatic sample_type dac_code(input logic [3:0] index);
      sample_type code;
      begin
         case (index)
            4'd0, 4'd1, 4'd2, 4'd3: code = 4'h0;
            4'd4:    code = 4'h2;
            4'd5:    code = 4'h1;
            4'd6:    code = 4'h3;
            4'd7:    code = 4'h5;
            4'd8:    code = 4'h7;
            4'd9:    code = 4'h9;
            4'd10:   code = 4'hB;
            4'd11:   code = 4'hD;
            default: code = 4'hF;
         endcase
         return code;
      end
   endfunction

endpackage

// File: rtl/cpse_lane.sv
// One sample lane of the composite pixel sample encoder.
// Forms the amplitude index of one sample and maps it to a DAC code.
// Depends on cpse_pkg.
module cpse_lane (
   input  logic [1:0]           luma,
   input  logic [3:0]           phase,
   input  logic [3:0]           offset,
   input  logic                 chroma_on,
   output cpse_pkg::sample_type sample
);

   logic [4:0]        phase_sum;
   logic [3:0]        phase_wrapped;
   logic signed [2:0] sine;
   logic signed [5:0] index;

   always_comb begin
      // The phase is below twelve whenever chroma is on, so one subtract wraps it.
      phase_sum = {1'b0, phase} + {1'b0, offset};
      if (phase_sum >= 5'(cpse_pkg::PhaseSteps)) begin
         phase_wrapped = 4'(phase_sum - 5'(cpse_pkg::PhaseSteps));
      end else begin
         phase_wrapped = phase_sum[3:0];
      end
      sine = chroma_on ? cpse_pkg::sine_step(phase_wrapped) : 3'sd0;
      index = $signed({3'b000, luma, 1'b0}) + 6'(cpse_pkg::BlankIndex)
              + 6'(sine);
      sample = cpse_pkg::dac_code(index[3:0]);
   end

endmodule

// File: rtl/cpse_merge.sv
// Merging stage of the composite pixel sample encoder.
// Packs the four lane samples into two bytes behind an output register and a skid stage.
// Depends on cpse_pkg.
module cpse_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  cpse_pkg::sample_vec_type in_samples,
   output logic                     out_valid,
   input  logic                     out_stall,
   output logic [7:0]               out_first,
   output logic [7:0]               out_second
);

   logic [15:0] packed_in;
   logic [15:0] out_data_ff;
   logic [15:0] skid_data_ff;
   logic        out_valid_ff;
   logic        skid_valid_ff;
   logic        accept;
   logic        take;

   assign packed_in = {in_samples[0], in_samples[1], in_samples[2], in_samples[3]};
   assign in_stall  = skid_valid_ff;
   assign accept    = in_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_data_ff <= packed_in;
         end else begin
            skid_data_ff <= packed_in;
         end
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_first  = out_data_ff[15:8];
   assign out_second = out_data_ff[7:0];

endmodule

// File: rtl/composite_pixel_sample_encoder_top.sv
// Composite pixel sample encoder: top level.
// Splits each pixel byte over four cpse_lane instances and merges them in cpse_merge.
// Depends on cpse_pkg, cpse_lane and cpse_merge.
//
// Usage:
//   The request channel (req_valid, req_stall, req_pixel_byte) carries one
//   framebuffer byte per transaction: left luma in bits 7:6, chroma phase in
//   bits 5:2, right luma in bits 1:0. The response channel (rsp_valid,
//   rsp_stall, rsp_first_sample_pair, rsp_second_sample_pair) returns one
//   transaction per request, holding four 4-bit DAC codes, two per byte.
//   Four lanes compute the four samples at once; phase offsets of 0, 3, 6 and
//   9 steps select each lane's point on the twelve-step sine.
//   A taken request goes into the output register (the skid register while that
//   is held) and is offered on the response channel from there. Throughput is
//   one transaction per cycle while the receiver does not stall. When the
//   receiver stalls, the output holds and one further request is caught in a
//   skid register; req_stall rises only once that is full. csr_write_enable
//   with csr_write_data writes grayscale mode, which removes all chroma; the
//   user must write it only while the block is idle; the block does not enforce it.
//   Synchronous reset empties both registers and clears grayscale mode.
module composite_pixel_sample_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_pixel_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_first_sample_pair,
   output logic [7:0] rsp_second_sample_pair
);

   logic                     grayscale_mode_ff;
   logic [1:0]               left_luma;
   logic [1:0]               right_luma;
   logic [3:0]               phase;
   logic                     chroma_on;
   cpse_pkg::sample_vec_type samples;

   // Configuration register: grayscale mode.
   always_ff @(posedge clock) begin
      if (reset) begin
         grayscale_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         grayscale_mode_ff <= csr_write_data;
      end
   end

   // Field split. Phases twelve to fifteen, like grayscale mode, carry no chroma.
   assign left_luma  = req_pixel_byte[7:6];
   assign right_luma = req_pixel_byte[1:0];
   assign phase      = req_pixel_byte[5:2];
   assign chroma_on  = !grayscale_mode_ff && (phase < 4'(cpse_pkg::PhaseSteps));

   // The left pixel feeds samples 0 and 1, the right pixel samples 2 and 3.
   cpse_lane u_lane_0 (
      .luma      (left_luma),
      .phase     (phase),
      .offset    (cpse_pkg::LANE_OFFSET_0),
      .chroma_on (chroma_on),
      .sample    (samples[0])
   );

   cpse_lane u_lane_1 (
      .luma      (left_luma),
      .phase     (phase),
      .offset    (cpse_pkg::LANE_OFFSET_1),
      .chroma_on (chroma_on),
      .sample    (samples[1])
   );

   cpse_lane u_lane_2 (
      .luma      (right_luma),
      .phase     (phase),
      .offset    (cpse_pkg::LANE_OFFSET_2),
      .chroma_on (chroma_on),
      .sample    (samples[2])
   );

   cpse_lane u_lane_3 (
      .luma      (right_luma),
      .phase     (phase),
      .offset    (cpse_pkg::LANE_OFFSET_3),
      .chroma_on (chroma_on),
      .sample    (samples[3])
   );

   // Packing, output register and skid stage.
   cpse_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_samples (samples),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_first  (rsp_first_sample_pair),
      .out_second (rsp_second_sample_pair)
   );

`ifndef SYNTHESIS
   // The skid register only fills behind a held output.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("skid stage full while output register empty");

   // An accepted request always leaves the output register valid at the next edge.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted transaction did not reach the output");

   // With the receiver free, the skid stage never fills.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_stall && !req_stall) |=> !req_stall)
      else $error("skid stage filled without a stall");
`endif

endmodule

// File: sim/tb_composite_pixel_sample_encoder_top.sv
// Self-checking testbench for composite_pixel_sample_encoder_top.
// Predicts every sample pair from the pixel byte and the grayscale setting, with random idling.
// Depends on cpse_pkg and on the RTL of the encoder only.
`timescale 1ns / 1ps

module tb_composite_pixel_sample_encoder_top;

   // One expected response transaction: the two packed sample pairs.
   typedef struct packed {
      logic [7:0] first_pair;
      logic [7:0] second_pair;
   } sample_pairs_type;

   // DAC code for each amplitude index, index 0 in the lowest nibble.
   localparam logic [63:0] DacCodeTable = 64'hFFFF_DB97_5312_0000;
   // Sine step at each of the twelve phases, stored with a bias of two so that
   // every entry is a non-negative nibble; phase 0 sits in the lowest nibble.
   localparam logic [47:0] SineBiased = 48'h1000_1234_4432;
   localparam int unsigned SineBias = 2;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic       csr_write_data;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_pixel_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_first_sample_pair;
   logic [7:0] rsp_second_sample_pair;

   sample_pairs_type pending_pairs[$];
   sample_pairs_type oldest_pair;
   logic             grayscale_shadow;
   int               mismatch_count;
   int               accepted_pixels;
   int               checked_pairs;
   int               chroma_pixels;
   int               plain_luma_pixels;
   int               burst_left;
   bit               sender_gaps_on;
   bit               receiver_stalls_on;
   int               stall_cycles_left;

   composite_pixel_sample_encoder_top dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_pixel_byte         (req_pixel_byte),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_first_sample_pair  (rsp_first_sample_pair),
      .rsp_second_sample_pair (rsp_second_sample_pair)
   );

   // 8 ns clock, starting low.
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // DAC code of one lane: twice the luma plus the blanking level, plus the sine
   // step at the lane's point on the twelve-step cycle when chroma is on.
   function automatic logic [3:0] lane_code(input logic [1:0] luma, input logic [3:0] phase,
                                             input int unsigned lane_offset,
                                             input logic chroma_on);
      int unsigned level;
      int unsigned slot;
      begin
         level = 2 * luma + cpse_pkg::BlankIndex;
         if (chroma_on) begin
            slot = (phase + lane_offset) % cpse_pkg::PhaseSteps;
            level = level + SineBiased[slot*4 +: 4] - SineBias;
         end
         return DacCodeTable[level*4 +: 4];
      end
   endfunction

   // Both sample pairs for one pixel byte. The left luma drives lanes 0 and 1,
   // the right luma lanes 2 and 3. Phases 12 to 15 and grayscale mode give the
   // plain luma level on every lane.
   function automatic sample_pairs_type encode_pixel(input logic [7:0] pixel, input logic gray);
      logic             chroma_on;
      sample_pairs_type pairs;
      begin
         chroma_on = !gray && (pixel[5:2] < cpse_pkg::PhaseSteps);
         pairs.first_pair  = {lane_code(pixel[7:6], pixel[5:2], cpse_pkg::LANE_OFFSET_0, chroma_on),
                              lane_code(pixel[7:6], pixel[5:2], cpse_pkg::LANE_OFFSET_1, chroma_on)};
         pairs.second_pair = {lane_code(pixel[1:0], pixel[5:2], cpse_pkg::LANE_OFFSET_2, chroma_on),
                              lane_code(pixel[1:0], pixel[5:2], cpse_pkg::LANE_OFFSET_3, chroma_on)};
         return pairs;
      end
   endfunction

   // Both channels are watched at the rising edge. A request taken here is
   // queued before the response is looked at, so a result can never be
   // checked ahead of its own request, whatever the latency turns out to be.
   // The grayscale shadow follows the register write at the same edge as the
   // block; writes only ever happen while nothing is in flight.
   always @(posedge clock) begin
      if (reset) begin
         grayscale_shadow = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_pairs.push_back(encode_pixel(req_pixel_byte, grayscale_shadow));
            accepted_pixels++;
            if (!grayscale_shadow && req_pixel_byte[5:2] < cpse_pkg::PhaseSteps)
               chroma_pixels++;
            else
               plain_luma_pixels++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_pairs.size() == 0) begin
               $display("%0t: response with nothing expected: first %h, second %h",
                        $time, rsp_first_sample_pair, rsp_second_sample_pair);
               mismatch_count++;
            end else begin
               oldest_pair = pending_pairs.pop_front();
               checked_pairs++;
               if (rsp_first_sample_pair !== oldest_pair.first_pair) begin
                  $display("%0t: first_sample_pair expected %h, actual %h",
                           $time, oldest_pair.first_pair, rsp_first_sample_pair);
                  mismatch_count++;
               end
               if (rsp_second_sample_pair !== oldest_pair.second_pair) begin
                  $display("%0t: second_sample_pair expected %h, actual %h",
                           $time, oldest_pair.second_pair, rsp_second_sample_pair);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable)
            grayscale_shadow = csr_write_data;
      end
   end

   // The receiver alternates between runs of readiness and runs of stalling,
   // with the odd long stall so that the skid register fills and the request
   // side is pushed back. Lengths of zero let the pattern flip every cycle.
   always @(negedge clock) begin
      if (!receiver_stalls_on) begin
         rsp_stall = 1'b0;
         stall_cycles_left = 0;
      end else if (stall_cycles_left != 0) begin
         stall_cycles_left--;
      end else begin
         rsp_stall = ~rsp_stall;
         if (rsp_stall)
            stall_cycles_left = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 30)
                                                             : $urandom_range(0, 3);
         else
            stall_cycles_left = $urandom_range(0, 8);
      end
   end

   // Offers one pixel byte and holds it until the block takes it. When gaps are
   // on, the sender works in bursts and leaves valid low for a random gap, which
   // may be none, between them; within a burst valid stays high from one byte to
   // the next.
   task automatic send_pixel(input logic [7:0] pixel);
      int gap;
      begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
               @(negedge clock);
               req_valid = 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         @(negedge clock);
         req_valid = 1'b1;
         req_pixel_byte = pixel;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         burst_left--;
      end
   endtask

   // Stops sending and waits until every queued response has come back, then
   // lets the output stage settle.
   task automatic wait_until_drained;
      begin
         @(negedge clock);
         req_valid = 1'b0;
         burst_left = 0;
         while (pending_pairs.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
      end
   endtask

   // Writes grayscale mode once the block has gone quiet.
   task automatic write_grayscale_mode(input logic mode);
      begin
         wait_until_drained();
         @(negedge clock);
         csr_write_enable = 1'b1;
         csr_write_data = mode;
         @(negedge clock);
         csr_write_enable = 1'b0;
      end
   endtask

   // Random pixel byte; three times in four the phase carries chroma.
   function automatic logic [7:0] random_pixel();
      logic [3:0] phase;
      begin
         if ($urandom_range(0, 3) != 0)
            phase = 4'($urandom_range(0, cpse_pkg::PhaseSteps - 1));
         else
            phase = 4'($urandom_range(cpse_pkg::PhaseSteps, 15));
         return {2'($urandom_range(0, 3)), phase, 2'($urandom_range(0, 3))};
      end
   endfunction

   // Palette mode: the luma extremes, every phase including the four that
   // carry no chroma, with each luma level cycling through the phases on both pixels.
   task automatic test_directed_palette;
      int phase;
      begin
         sender_gaps_on = 1'b0;
         receiver_stalls_on = 1'b0;
         write_grayscale_mode(1'b0);
         send_pixel(8'h00);
         send_pixel(8'hFF);
         send_pixel(8'hC3);
         send_pixel(8'h3C);
         for (phase = 0; phase < 16; phase++)
            send_pixel({2'(phase % 4), 4'(phase), 2'(3 - phase % 4)});
         wait_until_drained();
      end
   endtask

   // Grayscale mode: the phase bits must make no difference, so lumas are sent
   // with phases, most of them chroma phases, that would otherwise swing the samples.
   task automatic test_directed_grayscale;
      begin
         write_grayscale_mode(1'b1);
         send_pixel(8'h00);
         send_pixel(8'hFF);
         send_pixel(8'h3C);
         send_pixel(8'h55);
         send_pixel(8'hAA);
         send_pixel(8'hD7);
         wait_until_drained();
      end
   endtask

   // Long random palette run with both sides idling. Half way through, the
   // sender holds off until every response has arrived and then starts again.
   task automatic test_random_palette;
      int n;
      begin
         write_grayscale_mode(1'b0);
         sender_gaps_on = 1'b1;
         receiver_stalls_on = 1'b1;
         for (n = 0; n < 450; n++) begin
            if (n == 225)
               wait_until_drained();
            send_pixel(random_pixel());
         end
         wait_until_drained();
      end
   endtask

   // Random grayscale run with the same idling.
   task automatic test_random_grayscale;
      int n;
      begin
         write_grayscale_mode(1'b1);
         sender_gaps_on = 1'b1;
         receiver_stalls_on = 1'b1;
         for (n = 0; n < 200; n++)
            send_pixel(random_pixel());
         wait_until_drained();
      end
   endtask

   // Back-to-back transactions in palette mode: first with no idling at all,
   // so the block must sustain one transaction per cycle, then with only the
   // receiver stalling so that the skid register is exercised under full load.
   task automatic test_streaming_palette;
      int n;
      begin
         write_grayscale_mode(1'b0);
         sender_gaps_on = 1'b0;
         receiver_stalls_on = 1'b0;
         for (n = 0; n < 100; n++)
            send_pixel(random_pixel());
         receiver_stalls_on = 1'b1;
         for (n = 0; n < 80; n++)
            send_pixel(random_pixel());
         wait_until_drained();
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_valid = 1'b0;
      req_pixel_byte = 8'h00;
      rsp_stall = 1'b0;
      grayscale_shadow = 1'b0;
      mismatch_count = 0;
      accepted_pixels = 0;
      checked_pairs = 0;
      chroma_pixels = 0;
      plain_luma_pixels = 0;
      burst_left = 0;
      sender_gaps_on = 1'b0;
      receiver_stalls_on = 1'b0;
      stall_cycles_left = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_palette();
      test_directed_grayscale();
      test_random_palette();
      test_random_grayscale();
      test_streaming_palette();

      // Anything still queued at this point never came back.
      receiver_stalls_on = 1'b0;
      repeat (8) @(posedge clock);
      if (pending_pairs.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, pending_pairs.size());
         mismatch_count++;
      end

      $display("Sent %0d pixel bytes: %0d with chroma, %0d at plain luma level.",
               accepted_pixels, chroma_pixels, plain_luma_pixels);
      $display("Checked %0d sample pair responses in palette and grayscale mode.",
               checked_pairs);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // The slowest legal run needs well under half a millisecond.
   initial begin
      #2_000_000;
      $display("%0t: run did not finish in time", $time);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
